// File: rtl/adbc_pkg.sv
// ----------------------------------------------------------------------------
// adbc_pkg
// shared widths, constants and types of the averaged dimmer block
// ----------------------------------------------------------------------------
package adbc_pkg;

	localparam int SAMPLE_W = 12;

	// boxcar windows
	localparam int KNOB_WINDOW    = 100;
	localparam int BATTERY_WINDOW = 1000;

	localparam int KNOB_IDX_W = (KNOB_WINDOW > 1) ? $clog2(KNOB_WINDOW) : 1;
	localparam int KNOB_CNT_W = $clog2(KNOB_WINDOW + 1);
	localparam int KNOB_SUM_W = SAMPLE_W + KNOB_CNT_W;
	localparam int BAT_IDX_W  = (BATTERY_WINDOW > 1) ? $clog2(BATTERY_WINDOW) : 1;
	localparam int BAT_CNT_W  = $clog2(BATTERY_WINDOW + 1);
	localparam int BAT_SUM_W  = SAMPLE_W + BAT_CNT_W;

	// step = floor(sum*15 / (count*4096)), quotient always below 16
	localparam int STEP_W   = 4;
	localparam int STEP_MAX = 14;
	localparam int DIV_W    = KNOB_CNT_W + 16;
	localparam int DIV_SH_W = 2;

	// pwm = floor(level*64/7) = (level*18725) >> 11 for level <= 224
	localparam int LEVEL_W    = 8;
	localparam int PWM_W      = 12;
	localparam int PWM_RECIP  = 18725;
	localparam int PWM_SHIFT  = 11;
	localparam int PWM_PROD_W = 23;

	// battery compare: sum*16 against cutoff*count
	localparam int CUTOFF_W      = 16;
	localparam int CUTOFF_RESET  = 11284;
	localparam int BAT_CMP_W     = BAT_CNT_W + CUTOFF_W;

	// register file
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;
	localparam int REG_IDX_W    = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_CUTOFF = '0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_CLOAD,
		ST_COARSE,
		ST_FLOAD,
		ST_FINE,
		ST_LEVEL,
		ST_OUT
	} adbc_state_t;

	typedef struct packed {
		logic             load;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} adbc_div_req_t;

	typedef struct packed {
		logic              busy;
		logic [STEP_W-1:0] quot;
	} adbc_div_rsp_t;

endpackage

// File: rtl/adbc_if.sv
// ----------------------------------------------------------------------------
// adbc channel interfaces
// valid/ready channels for the sample triple and the dimmer result
// ----------------------------------------------------------------------------
interface adbc_in_if;
	logic                           valid;
	logic                           ready;
	logic [adbc_pkg::SAMPLE_W-1:0]  coarse_sample;
	logic [adbc_pkg::SAMPLE_W-1:0]  fine_sample;
	logic [adbc_pkg::SAMPLE_W-1:0]  battery_sample;

	modport source (output valid, coarse_sample, fine_sample, battery_sample, input ready);
	modport sink   (input valid, coarse_sample, fine_sample, battery_sample, output ready);
endinterface

interface adbc_out_if;
	logic                          valid;
	logic                          ready;
	logic [adbc_pkg::PWM_W-1:0]    pwm_level;
	logic [adbc_pkg::STEP_W-1:0]   coarse_step;
	logic [adbc_pkg::STEP_W-1:0]   fine_step;
	logic                          under_voltage;

	modport source (output valid, pwm_level, coarse_step, fine_step, under_voltage, input ready);
	modport sink   (input valid, pwm_level, coarse_step, fine_step, under_voltage, output ready);
endinterface

// File: rtl/adbc_div.sv
// ----------------------------------------------------------------------------
// adbc_div
// restoring divider, one quotient bit per cycle, four-bit quotient
// ----------------------------------------------------------------------------
module adbc_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  adbc_pkg::adbc_div_req_t req,
	output adbc_pkg::adbc_div_rsp_t rsp
);
	import adbc_pkg::*;

	logic [DIV_W-1:0]    rem_q;
	logic [DIV_W-1:0]    den_q;
	logic [STEP_W-1:0]   quot_q;
	logic [DIV_SH_W-1:0] sh_q;
	logic                busy_q;

	logic [DIV_W-1:0] den_sh;
	logic [DIV_W:0]   trial;

	assign den_sh = den_q << sh_q;
	assign trial  = {1'b0, rem_q} - {1'b0, den_sh};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sh_q   <= '0;
		end else if (req.load) begin
			busy_q <= 1'b1;
			sh_q   <= DIV_SH_W'(STEP_W - 1);
		end else if (busy_q) begin
			sh_q <= sh_q - DIV_SH_W'(1);
			if (sh_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			rem_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			// no borrow: this quotient bit is set
			if (!trial[DIV_W]) begin
				rem_q        <= trial[DIV_W-1:0];
				quot_q[sh_q] <= 1'b1;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quot = quot_q;

endmodule

// File: rtl/averaged_dimmer_with_battery_cutoff.sv
// ----------------------------------------------------------------------------
// averaged_dimmer_with_battery_cutoff
// boxcar-averaged two-knob dimmer with battery under-voltage cutoff
// ----------------------------------------------------------------------------
//  channel   dir  handshake        contents
//  samples   in   valid / ready    coarse, fine and battery converter samples
//  result    out  valid / ready    pwm_level, coarse_step, fine_step, under_voltage
//  apb       in   psel / penable   battery_cutoff at byte address 0
//
//  a sample transfer passes, from acceptance to result load, through one
//  window update, then a load and the iterations of the shared divider
//  per knob step, then a level state and an output state; the next
//  transfer is accepted only once the sequencer is back in idle
//  ready is high only in idle; a loaded result waits in its output register
//  while the next transfer is accepted, and a stalled result holds the
//  sequencer in its final state
//  reset clears sums, counts, pointers and the sequencer; ring memories are
//  not cleared, since a slot is only read back once the window is full
// ----------------------------------------------------------------------------
module averaged_dimmer_with_battery_cutoff (
	input  logic                                clk,
	input  logic                                arst_n,
	adbc_in_if.sink                             samples,
	adbc_out_if.source                          result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [adbc_pkg::PADDR_W-1:0]        paddr,
	input  logic [adbc_pkg::PDATA_W-1:0]        pwdata,
	output logic [adbc_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready
);
	import adbc_pkg::*;

	localparam logic [KNOB_IDX_W-1:0] KNOB_LAST = KNOB_IDX_W'(KNOB_WINDOW - 1);
	localparam logic [BAT_IDX_W-1:0]  BAT_LAST  = BAT_IDX_W'(BATTERY_WINDOW - 1);
	localparam logic [KNOB_CNT_W-1:0] KNOB_FULL = KNOB_CNT_W'(KNOB_WINDOW);
	localparam logic [BAT_CNT_W-1:0]  BAT_FULL  = BAT_CNT_W'(BATTERY_WINDOW);

	// ---------------- configuration register
	logic [CUTOFF_W-1:0]  cutoff_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_CUTOFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_W'(CUTOFF_RESET);
		end else if (cfg_wr) begin
			cutoff_q <= pwdata[CUTOFF_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_CUTOFF) begin
			prdata = PDATA_W'(cutoff_q);
		end
	end

	// ---------------- sequencer
	adbc_state_t state_q, state_d;
	logic        in_xfer;
	logic        out_load;
	logic        out_valid_q;
	adbc_div_req_t div_req;
	adbc_div_rsp_t div_rsp;

	// window state
	logic [SAMPLE_W-1:0]   coarse_q, fine_q, battery_q;
	logic [KNOB_SUM_W-1:0] coarse_sum_q, fine_sum_q;
	logic [BAT_SUM_W-1:0]  battery_sum_q;
	logic [KNOB_CNT_W-1:0] knob_cnt_q;
	logic [BAT_CNT_W-1:0]  bat_cnt_q;
	logic [KNOB_IDX_W-1:0] knob_ptr_q;
	logic [BAT_IDX_W-1:0]  bat_ptr_q;

	// per-item results
	logic [STEP_W-1:0]     cstep_q, fstep_q;
	logic [BAT_CMP_W-1:0]  bat_limit_q;
	logic                  under_q;
	logic [PWM_PROD_W-1:0] pwm_prod_q;

	assign samples.ready = (state_q == ST_IDLE);
	assign in_xfer       = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// knob numerator is sum*15, denominator count*4096
	always_comb begin
		state_d     = state_q;
		out_load    = 1'b0;
		div_req.load = 1'b0;
		div_req.num  = DIV_W'({coarse_sum_q, 4'b0000}) - DIV_W'(coarse_sum_q);
		div_req.den  = DIV_W'({knob_cnt_q, 12'b0});
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_CLOAD;
			end
			ST_CLOAD: begin
				div_req.load = 1'b1;
				state_d      = ST_COARSE;
			end
			ST_COARSE: begin
				if (!div_rsp.busy) begin
					state_d = ST_FLOAD;
				end
			end
			ST_FLOAD: begin
				div_req.load = 1'b1;
				div_req.num  = DIV_W'({fine_sum_q, 4'b0000}) - DIV_W'(fine_sum_q);
				state_d      = ST_FINE;
			end
			ST_FINE: begin
				if (!div_rsp.busy) begin
					state_d = ST_LEVEL;
				end
			end
			ST_LEVEL: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// output register free, or emptied in this cycle
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	adbc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------- ring memories, registered read of the oldest sample
	logic [2*SAMPLE_W-1:0] knob_mem [KNOB_WINDOW];
	logic [SAMPLE_W-1:0]   bat_mem  [BATTERY_WINDOW];
	logic [2*SAMPLE_W-1:0] knob_old_q;
	logic [SAMPLE_W-1:0]   bat_old_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			knob_mem[knob_ptr_q] <= {coarse_q, fine_q};
		end
		knob_old_q <= knob_mem[knob_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			bat_mem[bat_ptr_q] <= battery_q;
		end
		bat_old_q <= bat_mem[bat_ptr_q];
	end

	// ---------------- running sums, counts and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coarse_sum_q  <= '0;
			fine_sum_q    <= '0;
			battery_sum_q <= '0;
			knob_cnt_q    <= '0;
			bat_cnt_q     <= '0;
			knob_ptr_q    <= '0;
			bat_ptr_q     <= '0;
		end else if (state_q == ST_UPDATE) begin
			// full window: the oldest sample leaves as the new one enters
			if (knob_cnt_q == KNOB_FULL) begin
				coarse_sum_q <= coarse_sum_q + KNOB_SUM_W'(coarse_q)
					- KNOB_SUM_W'(knob_old_q[2*SAMPLE_W-1:SAMPLE_W]);
				fine_sum_q   <= fine_sum_q + KNOB_SUM_W'(fine_q)
					- KNOB_SUM_W'(knob_old_q[SAMPLE_W-1:0]);
			end else begin
				coarse_sum_q <= coarse_sum_q + KNOB_SUM_W'(coarse_q);
				fine_sum_q   <= fine_sum_q + KNOB_SUM_W'(fine_q);
				knob_cnt_q   <= knob_cnt_q + KNOB_CNT_W'(1);
			end
			if (bat_cnt_q == BAT_FULL) begin
				battery_sum_q <= battery_sum_q + BAT_SUM_W'(battery_q)
					- BAT_SUM_W'(bat_old_q);
			end else begin
				battery_sum_q <= battery_sum_q + BAT_SUM_W'(battery_q);
				bat_cnt_q     <= bat_cnt_q + BAT_CNT_W'(1);
			end
			knob_ptr_q <= (knob_ptr_q == KNOB_LAST) ? '0 : knob_ptr_q + KNOB_IDX_W'(1);
			bat_ptr_q  <= (bat_ptr_q == BAT_LAST) ? '0 : bat_ptr_q + BAT_IDX_W'(1);
		end
	end

	// ---------------- per-item datapath
	logic [LEVEL_W-1:0] level;
	logic [STEP_W-1:0]  quot_clamped;

	assign quot_clamped = (div_rsp.quot > STEP_W'(STEP_MAX)) ? STEP_W'(STEP_MAX) : div_rsp.quot;
	// level = coarse*15 + fine, at most 224
	assign level = LEVEL_W'({cstep_q, 4'b0000}) - LEVEL_W'(cstep_q) + LEVEL_W'(fstep_q);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			coarse_q  <= samples.coarse_sample;
			fine_q    <= samples.fine_sample;
			battery_q <= samples.battery_sample;
		end
		// cutoff*count is settled while the coarse step is worked out
		if (state_q == ST_COARSE) begin
			bat_limit_q <= BAT_CMP_W'(cutoff_q) * BAT_CMP_W'(bat_cnt_q);
			if (!div_rsp.busy) begin
				cstep_q <= quot_clamped;
			end
		end
		if (state_q == ST_FINE) begin
			under_q <= BAT_CMP_W'({battery_sum_q, 4'b0000}) < bat_limit_q;
			if (!div_rsp.busy) begin
				fstep_q <= quot_clamped;
			end
		end
		if (state_q == ST_LEVEL) begin
			pwm_prod_q <= PWM_PROD_W'(level) * PWM_PROD_W'(PWM_RECIP);
		end
	end

	// ---------------- output register
	logic [PWM_W-1:0] pwm_q;
	logic [STEP_W-1:0] cstep_out_q, fstep_out_q;
	logic              under_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pwm_q       <= under_q ? '0 : pwm_prod_q[PWM_SHIFT +: PWM_W];
			cstep_out_q <= cstep_q;
			fstep_out_q <= fstep_q;
			under_out_q <= under_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.pwm_level     = pwm_q;
	assign result.coarse_step   = cstep_out_q;
	assign result.fine_step     = fstep_out_q;
	assign result.under_voltage = under_out_q;

endmodule

// File: sim/tb_averaged_dimmer_with_battery_cutoff.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_averaged_dimmer_with_battery_cutoff
// self-checking bench for the boxcar-averaged dimmer with battery cutoff
//
// Sample triples are sent in bursts with random gaps, and results are drained
// through a receiver that stalls on its own pattern. Each accepted sample
// transfer updates a local model of the three boxcar windows, which predicts
// the steps, the pwm level and the under-voltage flag. Results are compared
// field by field in order. Between phases the sender waits for every result,
// and then the cutoff register is rewritten over APB and read back: zero,
// all ones, the full-scale boundary, a random value and values placed right at
// the current battery average; the first phase keeps the reset value.
// ----------------------------------------------------------------------------
module tb_averaged_dimmer_with_battery_cutoff;

	import adbc_pkg::*;

	// run shape
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 130;
	localparam int STALL_LIMIT  = 20000;
	localparam int END_CYCLES   = 40;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
	localparam int CUTOFF_MAX   = (1 << CUTOFF_W) - 1;

	// index past the single register, writes there must be ignored
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_CUTOFF + 1'b1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] coarse;
		logic [SAMPLE_W-1:0] fine;
		logic [SAMPLE_W-1:0] battery;
	} sample_t;

	typedef struct packed {
		logic [PWM_W-1:0]  pwm_level;
		logic [STEP_W-1:0] coarse_step;
		logic [STEP_W-1:0] fine_step;
		logic              under_voltage;
	} dimmer_result_t;

	// ------------------------------------------------------------------------
	// dimmer model and queue of pending results
	// ------------------------------------------------------------------------
	class dimmer_scoreboard;
		logic [SAMPLE_W-1:0] coarse_hist [KNOB_WINDOW];
		logic [SAMPLE_W-1:0] fine_hist [KNOB_WINDOW];
		logic [SAMPLE_W-1:0] battery_hist [BATTERY_WINDOW];
		longint unsigned     coarse_total;
		longint unsigned     fine_total;
		longint unsigned     battery_total;
		int unsigned         knob_held;
		int unsigned         battery_held;
		int unsigned         knob_slot;
		int unsigned         battery_slot;
		longint unsigned     cutoff;
		dimmer_result_t      expected_q[$];
		int                  mismatches;

		function new();
			coarse_total  = 0;
			fine_total    = 0;
			battery_total = 0;
			knob_held     = 0;
			battery_held  = 0;
			knob_slot     = 0;
			battery_slot  = 0;
			cutoff        = CUTOFF_RESET;
			mismatches    = 0;
		endfunction

		function void set_cutoff(logic [CUTOFF_W-1:0] value);
			cutoff = value;
		endfunction

		// averaged battery sample in sixteenths of a count
		function int unsigned battery_level16();
			if (battery_held == 0)
				return 0;
			return int'((battery_total * 16) / battery_held);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		function logic [STEP_W-1:0] knob_step(longint unsigned sum, int unsigned held);
			longint unsigned q;
			q = (sum * 15) / (longint'(held) * 4096);
			if (q > STEP_MAX)
				q = STEP_MAX;
			return q[STEP_W-1:0];
		endfunction

		function void note_sample(sample_t s);
			dimmer_result_t r;
			int unsigned    level;
			// knob windows: evict the oldest slot only once full
			if (knob_held < KNOB_WINDOW) begin
				knob_held++;
			end else begin
				coarse_total -= coarse_hist[knob_slot];
				fine_total   -= fine_hist[knob_slot];
			end
			coarse_hist[knob_slot] = s.coarse;
			fine_hist[knob_slot]   = s.fine;
			coarse_total += s.coarse;
			fine_total   += s.fine;
			knob_slot = (knob_slot + 1 >= KNOB_WINDOW) ? 0 : knob_slot + 1;
			// battery window
			if (battery_held < BATTERY_WINDOW) begin
				battery_held++;
			end else begin
				battery_total -= battery_hist[battery_slot];
			end
			battery_hist[battery_slot] = s.battery;
			battery_total += s.battery;
			battery_slot = (battery_slot + 1 >= BATTERY_WINDOW) ? 0 : battery_slot + 1;

			r.coarse_step   = knob_step(coarse_total, knob_held);
			r.fine_step     = knob_step(fine_total, knob_held);
			level           = r.coarse_step * 15 + r.fine_step;
			r.under_voltage = (battery_total * 16) < (cutoff * battery_held);
			r.pwm_level     = r.under_voltage ? '0 : PWM_W'((level * 64) / 7);
			expected_q.insert(expected_q.size(), r);
		endfunction

		function void check_result(dimmer_result_t got);
			dimmer_result_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("result with nothing pending (pwm_level %0d)", got.pwm_level));
				return;
			end
			want = expected_q[0];
			expected_q.delete(0);
			if (got.pwm_level !== want.pwm_level)
				flag($sformatf("pwm_level expected %0d, got %0d",
					want.pwm_level, got.pwm_level));
			if (got.coarse_step !== want.coarse_step)
				flag($sformatf("coarse_step expected %0d, got %0d",
					want.coarse_step, got.coarse_step));
			if (got.fine_step !== want.fine_step)
				flag($sformatf("fine_step expected %0d, got %0d",
					want.fine_step, got.fine_step));
			if (got.under_voltage !== want.under_voltage)
				flag($sformatf("under_voltage expected %0d, got %0d",
					want.under_voltage, got.under_voltage));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, channels and block
	// ------------------------------------------------------------------------
	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	adbc_in_if  samples_if ();
	adbc_out_if result_if ();

	dimmer_scoreboard sb;

	// receiver pattern state
	int rx_pct  = 100;
	int rx_left = 0;
	bit rx_free = 1'b0;

	// cycles since the last transfer of any kind
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	averaged_dimmer_with_battery_cutoff DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// ------------------------------------------------------------------------
	// receiver: segments of fixed ready probability, fully open when asked
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (rx_left == 0) begin
			case ($urandom_range(0, 4))
				0, 1: rx_pct = 100;
				2: rx_pct = 75;
				3: rx_pct = 40;
				default: rx_pct = 10;
			endcase
			rx_left = $urandom_range(10, 150);
		end else begin
			rx_left = rx_left - 1;
		end
		result_if.ready <= rx_free || ($urandom_range(0, 99) < rx_pct);
	end

	// ------------------------------------------------------------------------
	// monitor: values seen here are the ones present before the edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (samples_if.valid && samples_if.ready) begin
				sb.note_sample({samples_if.coarse_sample, samples_if.fine_sample,
					samples_if.battery_sample});
			end
			if (result_if.valid && result_if.ready) begin
				sb.check_result({result_if.pwm_level, result_if.coarse_step,
					result_if.fine_step, result_if.under_voltage});
			end
			if ((samples_if.valid && samples_if.ready) || (result_if.valid && result_if.ready)
					|| (psel && penable && pready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			// watchdog, nothing moving for too long
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// hold valid until the transfer; valid stays up for a following item
	task automatic send_sample(input sample_t s);
		samples_if.valid          <= 1'b1;
		samples_if.coarse_sample  <= s.coarse;
		samples_if.fine_sample    <= s.fine;
		samples_if.battery_sample <= s.battery;
		do @(posedge clk); while (!samples_if.ready);
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			samples_if.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// stop sending and wait for every pending result
	task automatic drain();
		samples_if.valid <= 1'b0;
		// let the monitor note the last transfer before pending results are polled
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// register write, then read back when the index is the cutoff register
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
		logic [PDATA_W-1:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_CUTOFF) begin
			sb.set_cutoff(data[CUTOFF_W-1:0]);
			@(posedge clk);
			psel   <= 1'b1;
			pwrite <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			got = prdata;
			psel    <= 1'b0;
			penable <= 1'b0;
			if (got[CUTOFF_W-1:0] !== data[CUTOFF_W-1:0])
				sb.flag($sformatf("battery_cutoff read back %0d, written %0d",
					got[CUTOFF_W-1:0], data[CUTOFF_W-1:0]));
		end
	endtask

	// sample around a center, clamped to the converter range
	function automatic logic [SAMPLE_W-1:0] jitter(input int center, input int spread);
		int v;
		v = center - spread + int'($urandom_range(0, 2 * spread));
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return v[SAMPLE_W-1:0];
	endfunction

	// bursts of samples; knob centers wander so every step gets reached
	task automatic run_phase(input int count, input bit gappy, input int bat_center,
			input int bat_spread);
		int      sent;
		int      burst;
		int      coarse_center;
		int      fine_center;
		int      knob_spread;
		sample_t s;
		sent          = 0;
		coarse_center = $urandom_range(0, SAMPLE_MAX);
		fine_center   = $urandom_range(0, SAMPLE_MAX);
		knob_spread   = 2048;
		while (sent < count) begin
			if ($urandom_range(0, 2) == 0) begin
				coarse_center = $urandom_range(0, SAMPLE_MAX);
				fine_center   = $urandom_range(0, SAMPLE_MAX);
				knob_spread   = ($urandom_range(0, 3) == 0) ? 2048 : $urandom_range(0, 300);
			end
			burst = $urandom_range(1, 30);
			repeat (burst) begin
				s.coarse  = jitter(coarse_center, knob_spread);
				s.fine    = jitter(fine_center, knob_spread);
				s.battery = jitter(bat_center, bat_spread);
				send_sample(s);
				sent++;
			end
			// gaps of zero keep some bursts back to back
			if (gappy)
				idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
		end
	endtask

	// ------------------------------------------------------------------------
	// directed samples: range extremes, alternating bits, step edges
	// (273 and 274 sit on either side of the first step boundary)
	// ------------------------------------------------------------------------
	sample_t directed [20] = '{
		{12'd0,    12'd0,    12'd0},
		{12'd4095, 12'd4095, 12'd4095},
		{12'd4095, 12'd0,    12'd4095},
		{12'd0,    12'd4095, 12'd0},
		{12'd4095, 12'd4095, 12'd4095},
		{12'd4095, 12'd4095, 12'd4095},
		{12'd273,  12'd274,  12'd705},
		{12'd274,  12'd273,  12'd706},
		{12'hAAA,  12'h555,  12'hAAA},
		{12'h555,  12'hAAA,  12'h555},
		{12'd2048, 12'd2047, 12'd0},
		{12'd4095, 12'd4095, 12'd4095},
		{12'd4095, 12'd4095, 12'd4095},
		{12'd4095, 12'd4095, 12'd4095},
		{12'd4095, 12'd4095, 12'd4095},
		{12'd4095, 12'd4095, 12'd4095},
		{12'd0,    12'd4095, 12'd4095},
		{12'd1,    12'd1,    12'd1},
		{12'd4094, 12'd4094, 12'd4094},
		{12'd0,    12'd0,    12'd0}
	};

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		int phase;
		int bat_center;
		int bat_spread;
		int threshold;
		arst_n                    <= 1'b0;
		psel                      <= 1'b0;
		penable                   <= 1'b0;
		pwrite                    <= 1'b0;
		paddr                     <= '0;
		pwdata                    <= '0;
		samples_if.valid          <= 1'b0;
		samples_if.coarse_sample  <= '0;
		samples_if.fine_sample    <= '0;
		samples_if.battery_sample <= '0;
		sb = new();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, under the reset cutoff, while the windows fill
		foreach (directed[k]) begin
			send_sample(directed[k]);
			idle_sender($urandom_range(0, 3));
		end
		drain();

		for (phase = 0; phase < PHASES; phase++) begin
			// one phase with neither side idling
			rx_free = (phase == 2);
			case (phase)
				0: begin
					// reset cutoff still in place
					bat_center = $urandom_range(0, SAMPLE_MAX);
					bat_spread = 2048;
				end
				1: begin
					// a write past the register list must leave the cutoff alone
					apb_write(REG_UNUSED, $urandom());
					apb_write(REG_CUTOFF, '0);
					bat_center = $urandom_range(0, SAMPLE_MAX);
					bat_spread = 2048;
				end
				2: begin
					// all ones, always under voltage
					apb_write(REG_CUTOFF, CUTOFF_MAX);
					bat_center = SAMPLE_MAX;
					bat_spread = 100;
				end
				5: begin
					apb_write(REG_CUTOFF, $urandom_range(0, CUTOFF_MAX));
					bat_center = $urandom_range(0, SAMPLE_MAX);
					bat_spread = $urandom_range(0, 2048);
				end
				7: begin
					// full-scale boundary: under unless every sample is at maximum
					apb_write(REG_CUTOFF, 16 * SAMPLE_MAX);
					bat_center = SAMPLE_MAX;
					bat_spread = 8;
				end
				default: begin
					// threshold right at the present battery average
					threshold = int'(sb.battery_level16()) + int'($urandom_range(0, 32)) - 16;
					if (threshold < 0)
						threshold = 0;
					if (threshold > CUTOFF_MAX)
						threshold = CUTOFF_MAX;
					apb_write(REG_CUTOFF, threshold);
					bat_center = sb.battery_level16() / 16;
					bat_spread = $urandom_range(20, 600);
				end
			endcase
			@(posedge clk);
			run_phase(PHASE_ITEMS, phase != 2, bat_center, bat_spread);
			// sender holds off until every result is back
			drain();
		end

		rx_free = 1'b0;
		repeat (END_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
